[hdl/dfs_pkg.sv]
// Shared types, character codes and the centering column table for the decimal formatter.
package dfs_pkg;

    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned DIGITS   = 10;
    localparam int unsigned BCD_W    = 4 * DIGITS;
    localparam int unsigned COL_W    = 7;
    localparam int unsigned ROW_W    = 3;
    localparam int unsigned CHAR_W   = 8;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_COMMA = 8'h2C;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic shift_digit;
    } t_dab_ctl;

    typedef struct packed {
        logic       busy;
        logic [3:0] top;
    } t_dab_sts;

    typedef struct packed {
        logic vld;
        logic comma;
        logic last;
    } t_emit;

    // Column that centers a text of the given digit count.
    function automatic logic [COL_W-1:0] center_col(input logic [3:0] ndig);
        logic [COL_W-1:0] col;
        unique case (ndig)
            4'd1:    col = 7'd61;
            4'd2:    col = 7'd58;
            4'd3:    col = 7'd55;
            4'd4:    col = 7'd49;
            4'd5:    col = 7'd46;
            4'd6:    col = 7'd43;
            4'd7:    col = 7'd37;
            4'd8:    col = 7'd34;
            4'd9:    col = 7'd31;
            4'd10:   col = 7'd25;
            default: col = 7'd61;
        endcase
        return col;
    endfunction

endpackage

[hdl/dfs_dabble.sv]
// Bit-serial binary to BCD converter with a digit shift register for readout.
module dfs_dabble (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  dfs_pkg::t_dab_ctl              i_ctl,
    input  logic [dfs_pkg::VALUE_W-1:0]    i_value,
    output dfs_pkg::t_dab_sts              o_sts
);
    import dfs_pkg::*;

    logic [VALUE_W-1:0] r_bin;
    logic [BCD_W-1:0]   r_bcd;
    logic [4:0]         r_cnt;
    logic               r_busy;
    logic [BCD_W-1:0]   adj;

    // Add three to every digit of five or more before the shift.
    always_comb begin
        for (int d = 0; d < DIGITS; d++) begin
            if (r_bcd[4*d +: 4] >= 4'd5) begin
                adj[4*d +: 4] = r_bcd[4*d +: 4] + 4'd3;
            end else begin
                adj[4*d +: 4] = r_bcd[4*d +: 4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_ctl.load) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 5'd1;
            if (r_cnt == 5'd31) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_bin <= i_value;
            r_bcd <= '0;
        end else if (r_busy) begin
            r_bcd <= {adj[BCD_W-2:0], r_bin[VALUE_W-1]};
            r_bin <= {r_bin[VALUE_W-2:0], 1'b0};
        end else if (i_ctl.shift_digit) begin
            r_bcd <= {r_bcd[BCD_W-5:0], 4'd0};
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.top  = r_bcd[BCD_W-1 -: 4];

endmodule

[hdl/dfs_seq.sv]
// Sequencer: conversion wait, leading zero skip and character emission with commas.
module dfs_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_adv,
    input  dfs_pkg::t_dab_sts  i_sts,
    output dfs_pkg::t_dab_ctl  o_ctl,
    output dfs_pkg::t_emit     o_emit,
    output logic [3:0]         o_ndig
);
    import dfs_pkg::*;

    t_state     r_state;
    t_state     n_state;
    logic [3:0] r_ndig;
    logic [3:0] r_rem;
    logic [1:0] r_mod3;
    logic       r_comma;
    logic       skip;
    logic [1:0] mod3_dec;

    assign skip     = (i_sts.top == 4'd0) && (r_ndig > 4'd1);
    assign mod3_dec = (r_mod3 == 2'd0) ? 2'd2 : r_mod3 - 2'd1;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_valid) n_state = ST_CONV;
            ST_CONV: if (!i_sts.busy) n_state = ST_SKIP;
            ST_SKIP: if (!skip) n_state = ST_EMIT;
            ST_EMIT: if (i_adv && !r_comma && (r_rem == 4'd1)) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_stall = 1'b1;
        o_ctl   = '0;
        o_emit  = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_stall  = 1'b0;
                o_ctl.load = i_valid;
            end
            ST_CONV: ;
            ST_SKIP: o_ctl.shift_digit = skip;
            ST_EMIT: begin
                if (i_adv) begin
                    o_emit.vld = 1'b1;
                    if (r_comma) begin
                        o_emit.comma = 1'b1;
                    end else begin
                        o_ctl.shift_digit = 1'b1;
                        o_emit.last       = (r_rem == 4'd1);
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Digit count and position counters; r_mod3 follows r_rem modulo three.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_ndig  <= 4'd10;
                r_mod3  <= 2'd1;
                r_comma <= 1'b0;
            end
            ST_CONV: ;
            ST_SKIP: begin
                if (skip) begin
                    r_ndig <= r_ndig - 4'd1;
                    r_mod3 <= mod3_dec;
                    r_rem  <= r_ndig - 4'd1;
                end else begin
                    r_rem  <= r_ndig;
                end
            end
            ST_EMIT: begin
                if (i_adv) begin
                    if (r_comma) begin
                        r_comma <= 1'b0;
                    end else begin
                        r_rem   <= r_rem - 4'd1;
                        r_mod3  <= mod3_dec;
                        r_comma <= (r_rem != 4'd1) && (r_mod3 == 2'd1);
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_ndig = r_ndig;

endmodule

[hdl/decimal_format_with_separators.sv]
// Top level of the decimal text formatter with thousands separators.
// A request is accepted, converted to BCD bit serially, and its leading zero digits are then
// skipped, keeping at least one digit, before the first character is emitted.
// Characters then follow one per cycle while the output is not stalled; a new request is
// accepted only once the sequencer has emitted the last character of the previous one.
// Reset is synchronous and active low; it empties the output register and idles the sequencer.
module decimal_format_with_separators (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [dfs_pkg::VALUE_W-1:0]      i_value,
    input  logic [dfs_pkg::COL_W-1:0]        i_start_column,
    input  logic [dfs_pkg::ROW_W-1:0]        i_row,
    input  logic                             i_center,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [dfs_pkg::CHAR_W-1:0]       o_character,
    output logic [dfs_pkg::COL_W-1:0]        o_column,
    output logic [dfs_pkg::ROW_W-1:0]        o_row_out,
    output logic                             o_last
);
    import dfs_pkg::*;

    t_dab_ctl         dab_ctl;
    t_dab_sts         dab_sts;
    t_emit            emit;
    logic [3:0]       ndig;
    logic             adv;

    // Fields of the request that ride along with every character.
    logic [COL_W-1:0] r_start_column;
    logic [ROW_W-1:0] r_row;
    logic             r_center;

    // Output register: it parts the sequencer from a stalling receiver.
    logic              r_o_valid;
    logic [CHAR_W-1:0] r_character;
    logic [COL_W-1:0]  r_column;
    logic [ROW_W-1:0]  r_row_out;
    logic              r_last;

    // A new character may be loaded when the register is empty or being taken.
    assign adv = !r_o_valid || !i_stall;

    dfs_dabble u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (dab_ctl),
        .i_value (i_value),
        .o_sts   (dab_sts)
    );

    dfs_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_adv   (adv),
        .i_sts   (dab_sts),
        .o_ctl   (dab_ctl),
        .o_emit  (emit),
        .o_ndig  (ndig)
    );

    // The request's side fields are captured together with the value.
    always_ff @(posedge i_clk) begin
        if (dab_ctl.load) begin
            r_start_column <= i_start_column;
            r_row          <= i_row;
            r_center       <= i_center;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (emit.vld) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    // The digit count is final once emission starts, so the column is settled too.
    always_ff @(posedge i_clk) begin
        if (emit.vld) begin
            r_character <= emit.comma ? CHAR_COMMA : CHAR_ZERO + {4'd0, dab_sts.top};
            r_column    <= r_center ? center_col(ndig) : r_start_column;
            r_row_out   <= r_row;
            r_last      <= emit.last;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_character = r_character;
    assign o_column    = r_column;
    assign o_row_out   = r_row_out;
    assign o_last      = r_last;

endmodule

[hdl/dfs_checker.sv]
// Port-level checker for the decimal formatter and its bind to the top level.
module dfs_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic                             o_stall,
    input  logic                             o_valid,
    input  logic                             i_stall,
    input  logic [dfs_pkg::CHAR_W-1:0]       o_character,
    input  logic                             o_last
);
    import dfs_pkg::*;

    // A stalled result holds its character.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_character))
        else $error("stalled result changed");

    // An accepted request keeps the block busy in the next cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("request accepted while still idle");

    // A separator is never the final character.
    a_comma: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_character == CHAR_COMMA) |-> !o_last)
        else $error("text ends in a separator");

    // While a text is unfinished, no new request is taken.
    a_unfinished: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> o_stall)
        else $error("new request accepted mid text");

endmodule

bind decimal_format_with_separators dfs_checker u_dfs_checker (.*);
